[rtl/ihsv_pkg.sv]
// ----------------------------------------------------------------------------
// ihsv_pkg
// Shared types and constants of the image header stream validator.
// ----------------------------------------------------------------------------
package ihsv_pkg;

    localparam int COUNT_BITS = 16;
    localparam int COUNT_EFF  = (COUNT_BITS > 16) ? 16 : COUNT_BITS;
    localparam logic [15:0] COUNT_LIMIT = 16'((32'd1 << COUNT_EFF) - 32'd1);

    localparam logic [63:0] MIN_FILE     = 64'd36;
    localparam logic [31:0] MAGIC_RESET  = 32'h4646_4943;
    localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0]  CHAR_NUL     = 8'h00;

    typedef enum logic [2:0] {
        ROLE_FIXED    = 3'd0,
        ROLE_CAPTION  = 3'd1,
        ROLE_CAP_NL   = 3'd2,
        ROLE_TAG_CHAR = 3'd3,
        ROLE_TAG_END  = 3'd4,
        ROLE_PIXEL    = 3'd5,
        ROLE_IGNORED  = 3'd6
    } role_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT       = 3'd1,
        ST_MAGIC       = 3'd2,
        ST_HDR_SMALL   = 3'd3,
        ST_CONTENT_NEG = 3'd4,
        ST_SIZE        = 3'd5,
        ST_DIMS        = 3'd6,
        ST_TAG_NL      = 3'd7
    } status_t;

    typedef struct packed {
        role_t       role;
        logic        done;
        status_t     pre_status;
        logic        tag_fault;
        logic [63:0] width;
        logic [63:0] height;
        logic [63:0] content;
        logic [15:0] tags;
        logic [15:0] caption;
    } entry_t;

endpackage

[rtl/ihsv_in_if.sv]
// ----------------------------------------------------------------------------
// ihsv_in_if
// Byte channel: one file byte with its last-byte mark per word.
// ----------------------------------------------------------------------------
interface ihsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/ihsv_out_if.sv]
// ----------------------------------------------------------------------------
// ihsv_out_if
// Result channel: byte role plus end-of-file status per word.
// ----------------------------------------------------------------------------
interface ihsv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_role;
    logic        file_done;
    logic [2:0]  status_code;
    logic [62:0] image_width;
    logic [62:0] image_height;
    logic [15:0] tag_total;
    logic [15:0] caption_length;

    modport source (output valid, output byte_role, output file_done, output status_code,
                    output image_width, output image_height, output tag_total,
                    output caption_length, input ready);
    modport sink   (input valid, input byte_role, input file_done, input status_code,
                    input image_width, input image_height, input tag_total,
                    input caption_length, output ready);
endinterface

[rtl/ihsv_front.sv]
// ----------------------------------------------------------------------------
// ihsv_front
// Byte classifier: parses the fixed header, assigns roles, runs the early checks.
// ----------------------------------------------------------------------------
module ihsv_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     magic_word,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    output ihsv_pkg::entry_t entry
);

    typedef enum logic [1:0] {
        RG_FIXED   = 2'd0,
        RG_CAPTION = 2'd1,
        RG_TAGS    = 2'd2,
        RG_SKIP    = 2'd3
    } region_t;

    logic [63:0] pos_reg, pos_next;
    logic [63:0] hl_reg, hl_next;
    logic [63:0] cl_reg, cl_next;
    logic [63:0] w_reg, w_next;
    logic [63:0] h_reg, h_next;
    logic [31:0] magic_reg, magic_next;
    region_t     region_reg, region_next;
    logic        fault_reg, fault_next;
    logic [15:0] tags_reg, tags_next;
    logic [15:0] cap_reg, cap_next;
    logic [5:0]  off;
    logic        header_ok;
    ihsv_pkg::role_t   role;
    ihsv_pkg::status_t pre;

    assign header_ok = !hl_reg[63] && (hl_reg >= ihsv_pkg::MIN_FILE);
    assign off       = pos_reg[5:0] - 6'd4;

    always_comb
    begin
        pos_next    = (&pos_reg) ? pos_reg : pos_reg + 64'd1;
        hl_next     = hl_reg;
        cl_next     = cl_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        magic_next  = magic_reg;
        region_next = region_reg;
        fault_next  = fault_reg;
        tags_next   = tags_reg;
        cap_next    = cap_reg;
        role        = ihsv_pkg::ROLE_PIXEL;
        if (pos_reg < 64'd4)
        begin
            magic_next[8*pos_reg[1:0] +: 8] = data_byte;
            role = ihsv_pkg::ROLE_FIXED;
        end
        else if (pos_reg < ihsv_pkg::MIN_FILE)
        begin
            case (off[4:3])
                2'd0:    hl_next[8*off[2:0] +: 8] = data_byte;
                2'd1:    cl_next[8*off[2:0] +: 8] = data_byte;
                2'd2:    w_next[8*off[2:0] +: 8]  = data_byte;
                default: h_next[8*off[2:0] +: 8]  = data_byte;
            endcase
            role = ihsv_pkg::ROLE_FIXED;
            if (pos_reg == ihsv_pkg::MIN_FILE - 64'd1)
            begin
                region_next = RG_CAPTION;
            end
        end
        else if (header_ok && (pos_reg < hl_reg))
        begin
            unique case (region_reg)
                RG_CAPTION:
                begin
                    if (data_byte == ihsv_pkg::CHAR_NEWLINE)
                    begin
                        role        = ihsv_pkg::ROLE_CAP_NL;
                        region_next = RG_TAGS;
                    end
                    else
                    begin
                        role = ihsv_pkg::ROLE_CAPTION;
                        if (cap_reg < ihsv_pkg::COUNT_LIMIT)
                        begin
                            cap_next = cap_reg + 16'd1;
                        end
                    end
                end
                RG_TAGS:
                begin
                    if (data_byte == ihsv_pkg::CHAR_NEWLINE)
                    begin
                        role        = ihsv_pkg::ROLE_IGNORED;
                        region_next = RG_SKIP;
                        fault_next  = 1'b1;
                    end
                    else if (data_byte == ihsv_pkg::CHAR_NUL)
                    begin
                        role = ihsv_pkg::ROLE_TAG_END;
                        if (tags_reg < ihsv_pkg::COUNT_LIMIT)
                        begin
                            tags_next = tags_reg + 16'd1;
                        end
                    end
                    else
                    begin
                        role = ihsv_pkg::ROLE_TAG_CHAR;
                    end
                end
                default: role = ihsv_pkg::ROLE_IGNORED;
            endcase
        end

        if (pos_next < ihsv_pkg::MIN_FILE)
        begin
            pre = ihsv_pkg::ST_SHORT;
        end
        else if (magic_next != magic_word)
        begin
            pre = ihsv_pkg::ST_MAGIC;
        end
        else if (!header_ok)
        begin
            pre = ihsv_pkg::ST_HDR_SMALL;
        end
        else if (cl_reg[63])
        begin
            pre = ihsv_pkg::ST_CONTENT_NEG;
        end
        else if (cl_reg + hl_reg != pos_next)
        begin
            pre = ihsv_pkg::ST_SIZE;
        end
        else
        begin
            pre = ihsv_pkg::ST_OK;
        end

        entry.role       = role;
        entry.done       = last_byte;
        entry.pre_status = pre;
        entry.tag_fault  = fault_next;
        entry.width      = w_next;
        entry.height     = h_next;
        entry.content    = cl_next;
        entry.tags       = tags_next;
        entry.caption    = cap_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hl_reg     <= '0;
            cl_reg     <= '0;
            w_reg      <= '0;
            h_reg      <= '0;
            magic_reg  <= '0;
            region_reg <= RG_FIXED;
            fault_reg  <= 1'b0;
            tags_reg   <= '0;
            cap_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                pos_reg    <= '0;
                hl_reg     <= '0;
                cl_reg     <= '0;
                w_reg      <= '0;
                h_reg      <= '0;
                magic_reg  <= '0;
                region_reg <= RG_FIXED;
                fault_reg  <= 1'b0;
                tags_reg   <= '0;
                cap_reg    <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                hl_reg     <= hl_next;
                cl_reg     <= cl_next;
                w_reg      <= w_next;
                h_reg      <= h_next;
                magic_reg  <= magic_next;
                region_reg <= region_next;
                fault_reg  <= fault_next;
                tags_reg   <= tags_next;
                cap_reg    <= cap_next;
            end
        end
    end

endmodule

[rtl/ihsv_queue.sv]
// ----------------------------------------------------------------------------
// ihsv_queue
// Two-entry queue between classifier and checker.
// ----------------------------------------------------------------------------
module ihsv_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ihsv_pkg::entry_t wr_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output ihsv_pkg::entry_t rd_entry
);

    ihsv_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_entry  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/ihsv_back.sv]
// ----------------------------------------------------------------------------
// ihsv_back
// Checker: finishes the dimension check with a shared 32x32 multiplier, drives results.
// ----------------------------------------------------------------------------
module ihsv_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  ihsv_pkg::entry_t head,
    output logic             pop,
    ihsv_out_if.source       dst
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_MUL_LO = 3'd1,
        S_MUL_A  = 3'd2,
        S_MUL_B  = 3'd3,
        S_CHECK  = 3'd4
    } state_t;

    state_t      state_reg;
    logic [63:0] acc_reg;
    logic        out_valid_reg;
    logic [2:0]  role_reg;
    logic        done_reg;
    logic [2:0]  status_reg;
    logic [62:0] width_reg;
    logic [62:0] height_reg;
    logic [15:0] tags_reg;
    logic [15:0] cap_reg;

    logic        slot_free;
    logic        load_direct;
    logic        load_check;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [63:0] times3;
    logic        direct;
    ihsv_pkg::status_t fin;

    assign slot_free   = !out_valid_reg || dst.ready;
    assign direct      = !head.done || (head.pre_status != ihsv_pkg::ST_OK);
    assign load_direct = (state_reg == S_IDLE) && q_valid && slot_free && direct;
    assign load_check  = (state_reg == S_CHECK) && slot_free;
    assign times3      = acc_reg + {acc_reg[62:0], 1'b0};
    assign prod        = op_a * op_b;

    always_comb
    begin
        unique case (state_reg)
            S_MUL_A:
            begin
                op_a = head.width[31:0];
                op_b = head.height[63:32];
            end
            S_MUL_B:
            begin
                op_a = head.width[63:32];
                op_b = head.height[31:0];
            end
            default:
            begin
                op_a = head.width[31:0];
                op_b = head.height[31:0];
            end
        endcase

        if (head.width[63] || head.height[63] || (head.content != times3))
        begin
            fin = ihsv_pkg::ST_DIMS;
        end
        else if (head.tag_fault)
        begin
            fin = ihsv_pkg::ST_TAG_NL;
        end
        else
        begin
            fin = ihsv_pkg::ST_OK;
        end

        pop = 1'b0;
        if (state_reg == S_IDLE)
        begin
            pop = q_valid && slot_free && direct;
        end
        else if (state_reg == S_CHECK)
        begin
            pop = slot_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            role_reg      <= '0;
            done_reg      <= 1'b0;
            status_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            tags_reg      <= '0;
            cap_reg       <= '0;
        end
        else
        begin
            if (load_direct || load_check)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dst.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && slot_free && !direct)
                    begin
                        state_reg <= S_MUL_LO;
                    end
                end
                S_MUL_LO: state_reg <= S_MUL_A;
                S_MUL_A:  state_reg <= S_MUL_B;
                S_MUL_B:  state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase

            if (load_direct)
            begin
                role_reg   <= head.role;
                done_reg   <= head.done;
                status_reg <= head.done ? head.pre_status : ihsv_pkg::ST_OK;
                width_reg  <= '0;
                height_reg <= '0;
                tags_reg   <= '0;
                cap_reg    <= '0;
            end
            else if (load_check)
            begin
                role_reg   <= head.role;
                done_reg   <= 1'b1;
                status_reg <= fin;
                if (fin == ihsv_pkg::ST_DIMS)
                begin
                    width_reg  <= '0;
                    height_reg <= '0;
                    tags_reg   <= '0;
                    cap_reg    <= '0;
                end
                else
                begin
                    width_reg  <= head.width[62:0];
                    height_reg <= head.height[62:0];
                    tags_reg   <= head.tags;
                    cap_reg    <= head.caption;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_MUL_LO: acc_reg <= prod;
            S_MUL_A:  acc_reg <= acc_reg + {prod[31:0], 32'd0};
            S_MUL_B:  acc_reg <= acc_reg + {prod[31:0], 32'd0};
            default:  acc_reg <= acc_reg;
        endcase
    end

    assign dst.valid          = out_valid_reg;
    assign dst.byte_role      = role_reg;
    assign dst.file_done      = done_reg;
    assign dst.status_code    = status_reg;
    assign dst.image_width    = width_reg;
    assign dst.image_height   = height_reg;
    assign dst.tag_total      = tags_reg;
    assign dst.caption_length = cap_reg;

endmodule

[rtl/image_header_stream_validator_core.sv]
// ----------------------------------------------------------------------------
// image_header_stream_validator_core
// Classifies file bytes by role and reports header status on the last byte.
// ----------------------------------------------------------------------------
// The result word is registered behind the two-entry queue; a last byte that passes
// the early checks first takes three 32x32 partial products and a compare.
// Throughput: one byte per cycle while the queue is not full; each file end that
// passes the size check holds the back end through the multiply and check states.
// Reset: rst_n clears file state and queue; magic_word returns to its default.
// ----------------------------------------------------------------------------
module image_header_stream_validator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    ihsv_in_if.sink     byte_in,
    ihsv_out_if.source  result_out
);

    logic [31:0]      magic_reg;
    logic             accept;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    ihsv_pkg::entry_t fr_entry;
    ihsv_pkg::entry_t q_head;

    assign byte_in.ready = !q_full;
    assign accept        = byte_in.valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= ihsv_pkg::MAGIC_RESET;
        end
        else if (cfg_we)
        begin
            magic_reg <= cfg_wdata;
        end
    end

    ihsv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .magic_word (magic_reg),
        .accept     (accept),
        .data_byte  (byte_in.data_byte),
        .last_byte  (byte_in.last_byte),
        .entry      (fr_entry)
    );

    ihsv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .wr_entry  (fr_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_entry  (q_head)
    );

    ihsv_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (q_head),
        .pop     (q_pop),
        .dst     (result_out)
    );

endmodule

[verif/ihsv_result_checker.sv]
// ----------------------------------------------------------------------------
// ihsv_result_checker
// Watches the byte and result channels, predicts the role and end-of-file
// status of every accepted byte and compares each result word in order.
// ----------------------------------------------------------------------------
module ihsv_result_checker
    import ihsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    ihsv_in_if          byte_in,
    ihsv_out_if         result_out,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        role_t       role;
        logic        done;
        status_t     status;
        logic [62:0] width;
        logic [62:0] height;
        logic [15:0] tags;
        logic [15:0] caption;
    } result_word_t;

    result_word_t expected_words[$];

    logic [31:0] magic_reg;
    logic [63:0] pos_cnt;
    logic [63:0] hdr_len;
    logic [63:0] cont_len;
    logic [63:0] width_val;
    logic [63:0] height_val;
    logic [31:0] magic_acc;
    logic [1:0]  region;
    logic        tag_nl_seen;
    logic [15:0] tag_cnt;
    logic [15:0] cap_cnt;

    assign pending = expected_words.size();

    task automatic clear_file();
        pos_cnt = '0; hdr_len = '0; cont_len = '0; width_val = '0; height_val = '0;
        magic_acc = '0; region = 2'd0; tag_nl_seen = 1'b0; tag_cnt = '0; cap_cnt = '0;
    endtask

    task automatic classify_byte(input logic [7:0] b, input logic last);
        result_word_t w;
        logic         hdr_ok;
        logic [63:0]  v;
        logic [63:0]  total;
        status_t      st;
        hdr_ok = !hdr_len[63] && hdr_len >= MIN_FILE;
        w = '0;
        if (pos_cnt < 64'd4) begin
            magic_acc = magic_acc | (32'(b) << (8 * pos_cnt[1:0]));
            w.role = ROLE_FIXED;
        end
        else if (pos_cnt < MIN_FILE) begin
            v = 64'(b) << (8 * ((pos_cnt - 64'd4) & 64'd7));
            if (pos_cnt < 64'd12)      hdr_len    = hdr_len | v;
            else if (pos_cnt < 64'd20) cont_len   = cont_len | v;
            else if (pos_cnt < 64'd28) width_val  = width_val | v;
            else                       height_val = height_val | v;
            w.role = ROLE_FIXED;
            if (pos_cnt == MIN_FILE - 64'd1) region = 2'd1;
        end
        else if (hdr_ok && pos_cnt < hdr_len) begin
            if (region == 2'd1) begin
                if (b == CHAR_NEWLINE) begin
                    w.role = ROLE_CAP_NL;
                    region = 2'd2;
                end
                else begin
                    w.role = ROLE_CAPTION;
                    if (cap_cnt < COUNT_LIMIT) cap_cnt++;
                end
            end
            else if (region == 2'd2) begin
                if (b == CHAR_NEWLINE) begin
                    w.role = ROLE_IGNORED;
                    region = 2'd3;
                    tag_nl_seen = 1'b1;
                end
                else if (b == CHAR_NUL) begin
                    w.role = ROLE_TAG_END;
                    if (tag_cnt < COUNT_LIMIT) tag_cnt++;
                end
                else begin
                    w.role = ROLE_TAG_CHAR;
                end
            end
            else begin
                w.role = ROLE_IGNORED;
            end
        end
        else begin
            w.role = ROLE_PIXEL;
        end
        if (pos_cnt != '1) pos_cnt++;
        if (last) begin
            total = pos_cnt;
            if (total < MIN_FILE)                          st = ST_SHORT;
            else if (magic_acc != magic_reg)               st = ST_MAGIC;
            else if (!hdr_ok)                              st = ST_HDR_SMALL;
            else if (cont_len[63])                         st = ST_CONTENT_NEG;
            else if (cont_len + hdr_len != total)          st = ST_SIZE;
            else if (width_val[63] || height_val[63] ||
                     cont_len != width_val * height_val * 64'd3) st = ST_DIMS;
            else if (tag_nl_seen)                          st = ST_TAG_NL;
            else                                           st = ST_OK;
            w.done = 1'b1;
            w.status = st;
            if (st == ST_OK || st == ST_TAG_NL) begin
                w.width   = width_val[62:0];
                w.height  = height_val[62:0];
                w.tags    = tag_cnt;
                w.caption = cap_cnt;
            end
            clear_file();
        end
        expected_words.insert(expected_words.size(), w);
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] e,
                                 input logic [63:0] a);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0h, got %0h", field, e, a);
    endtask

    task automatic compare_word();
        result_word_t e;
        if (expected_words.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result word");
            return;
        end
        e = expected_words.pop_front();
        if (result_out.byte_role != e.role)
            note_mismatch("byte_role", 64'(e.role), 64'(result_out.byte_role));
        if (result_out.file_done != e.done)
            note_mismatch("file_done", 64'(e.done), 64'(result_out.file_done));
        if (result_out.status_code != e.status)
            note_mismatch("status_code", 64'(e.status), 64'(result_out.status_code));
        if (result_out.image_width != e.width)
            note_mismatch("image_width", 64'(e.width), 64'(result_out.image_width));
        if (result_out.image_height != e.height)
            note_mismatch("image_height", 64'(e.height), 64'(result_out.image_height));
        if (result_out.tag_total != e.tags)
            note_mismatch("tag_total", 64'(e.tags), 64'(result_out.tag_total));
        if (result_out.caption_length != e.caption)
            note_mismatch("caption_length", 64'(e.caption), 64'(result_out.caption_length));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            magic_reg <= MAGIC_RESET;
            fail_count = 0;
            clear_file();
            expected_words.delete();
        end
        else begin
            if (result_out.valid && result_out.ready) compare_word();
            if (byte_in.valid && byte_in.ready)
                classify_byte(byte_in.data_byte, byte_in.last_byte);
            if (cfg_we) magic_reg <= cfg_wdata;
        end
    end
endmodule

[verif/image_header_stream_validator_core_tb.sv]
// ----------------------------------------------------------------------------
// image_header_stream_validator_core_tb
// Streams well-formed and damaged image files through the validator under
// varying sender and receiver stalls and magic settings; the checker
// compares every result word against its own prediction.
// ----------------------------------------------------------------------------
module image_header_stream_validator_core_tb;
    import ihsv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        FK_GOOD, FK_SHORT, FK_MAGIC, FK_HDR_SMALL, FK_CONT_NEG, FK_SIZE,
        FK_DIMS, FK_TAG_NL, FK_NO_CAP_NL, FK_OPEN_TAG, FK_NOISE
    } file_kind_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    logic [31:0] magic_now;
    logic [7:0]  file_bytes[$];

    ihsv_in_if  byte_ch();
    ihsv_out_if result_ch();

    image_header_stream_validator_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    ihsv_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_in    (byte_ch),
        .result_out (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic add_byte(input logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endtask

    task automatic put64(input logic [63:0] v);
        for (int i = 0; i < 8; i++) add_byte(v[8*i +: 8]);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == CHAR_NEWLINE) c = 8'h41;
        return c;
    endfunction

    task automatic build_file(input file_kind_t kind);
        logic [7:0]  tail[$];
        logic [63:0] hdr;
        logic [63:0] cont;
        logic [63:0] wd;
        logic [63:0] ht;
        logic [31:0] mg;
        int          npix;
        int          ntags;
        file_bytes.delete();
        if (kind == FK_NOISE) begin
            repeat ($urandom_range(1, 60)) add_byte(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 6)) tail.insert(tail.size(), plain_char());
        if (kind != FK_NO_CAP_NL) begin
            tail.insert(tail.size(), CHAR_NEWLINE);
            ntags = $urandom_range(0, 3);
            for (int t = 0; t < ntags; t++) begin
                repeat ($urandom_range(0, 3)) tail.insert(tail.size(), plain_char());
                if (kind == FK_TAG_NL && t == ntags - 1) tail.insert(tail.size(), CHAR_NEWLINE);
                tail.insert(tail.size(), CHAR_NUL);
            end
            if (kind == FK_TAG_NL && ntags == 0) tail.insert(tail.size(), CHAR_NEWLINE);
            if (kind == FK_OPEN_TAG) tail.insert(tail.size(), plain_char());
        end
        wd = 64'($urandom_range(0, 4));
        ht = 64'($urandom_range(0, 4));
        npix = int'(wd * ht * 3);
        cont = 64'(npix);
        hdr = 64'd36 + 64'(tail.size());
        mg = magic_now;
        case (kind)
            FK_MAGIC:     mg = mg ^ (32'd1 << $urandom_range(31));
            FK_HDR_SMALL: hdr = $urandom_range(1) ? {1'b1, 31'($urandom), 32'($urandom)}
                                                  : 64'($urandom_range(0, 35));
            FK_CONT_NEG:  cont = {1'b1, 31'($urandom), 32'($urandom)};
            FK_DIMS:
            begin
                if ($urandom_range(1)) wd = {1'b1, 31'($urandom), 32'($urandom)};
                else ht = {1'($urandom), 31'($urandom), 32'($urandom)};
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) add_byte(mg[8*i +: 8]);
        put64(hdr);
        put64(cont);
        put64(wd);
        put64(ht);
        foreach (tail[i]) add_byte(tail[i]);
        repeat (npix) add_byte(8'($urandom));
        if (kind == FK_SIZE) begin
            if (file_bytes.size() > 36 && $urandom_range(1)) void'(file_bytes.pop_back());
            else repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        end
        if (kind == FK_SHORT) begin
            while (file_bytes.size() > 35) void'(file_bytes.pop_back());
            repeat ($urandom_range(0, 34)) void'(file_bytes.pop_back());
        end
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
        begin
            while ($urandom_range(99) < idle_pct) begin
                byte_ch.valid <= 1'b0;
                @(posedge clk);
            end
            byte_ch.valid     <= 1'b1;
            byte_ch.data_byte <= file_bytes[i];
            byte_ch.last_byte <= (i == file_bytes.size() - 1);
            @(posedge clk);
            while (!byte_ch.ready) @(posedge clk);
        end
    endtask

    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_magic(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        magic_now = v;
    endtask

    initial
    begin
        int          phase_bytes;
        int          idle_tab[4];
        int          stall_tab[4];
        logic [31:0] magic_tab[4];
        idle_tab  = '{0, 59, 0, 20};
        stall_tab = '{0, 0, 59, 20};
        magic_tab = '{MAGIC_RESET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0};
        magic_tab[3] = $urandom;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        magic_now = MAGIC_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = int'(FK_GOOD); k <= int'(FK_NOISE); k++) begin
            build_file(file_kind_t'(k));
            send_file();
        end
        file_bytes = '{8'h7F};
        send_file();
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            if (p > 0) write_magic(magic_tab[p]);
            phase_bytes = 0;
            while (phase_bytes < 55) begin
                if ($urandom_range(99) < 55) build_file(FK_GOOD);
                else build_file(file_kind_t'($urandom_range(int'(FK_SHORT), int'(FK_NOISE))));
                phase_bytes += file_bytes.size();
                send_file();
                if ($urandom_range(9) == 0) begin
                    while ($urandom_range(99) < 60) begin
                        byte_ch.valid <= 1'b0;
                        @(posedge clk);
                    end
                end
            end
            drain();
        end
        write_magic(MAGIC_RESET);
        build_file(FK_GOOD);
        send_file();
        drain();

        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
